/* sv/sqvb_pkg.sv */
package sqvb_pkg;

  // batch geometry
  localparam int unsigned BATCH_VERTICES = 32768;
  localparam int unsigned SLOT_W = 15;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // colour constants
  localparam logic [23:0] WHITE_TINT = 24'hFFFFFF;
  localparam logic [8:0] ALPHA_ONE = 9'd256;
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // operation codes on the input channel
  localparam logic OP_QUAD = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // register indexes on the config port
  localparam logic [2:0] REG_M_XX = 3'd0;
  localparam logic [2:0] REG_M_XY = 3'd1;
  localparam logic [2:0] REG_M_XT = 3'd2;
  localparam logic [2:0] REG_M_YX = 3'd3;
  localparam logic [2:0] REG_M_YY = 3'd4;
  localparam logic [2:0] REG_M_YT = 3'd5;
  localparam logic [2:0] REG_TINT = 3'd6;
  localparam logic [2:0] REG_OPACITY = 3'd7;

  // configuration seen by the back end
  typedef struct packed {
    logic [31:0] m_xx;
    logic [31:0] m_xy;
    logic [31:0] m_xt;
    logic [31:0] m_yx;
    logic [31:0] m_yy;
    logic [31:0] m_yt;
    logic [23:0] tint_color;
    logic [8:0]  opacity;
  } cfg_t;

  // one classified command between front and back
  typedef struct packed {
    logic              flush_only;
    logic              flush_first;
    logic [SLOT_W-1:0] base_slot;
    logic [31:0]       left_x;
    logic [31:0]       top_y;
    logic [31:0]       right_x;
    logic [31:0]       bottom_y;
    logic [3:0][31:0]  tex;
  } cmd_t;

endpackage

/* sv/sqvb_front.sv */
module sqvb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [31:0]         left_x,
  input  logic [31:0]         top_y,
  input  logic [31:0]         right_x,
  input  logic [31:0]         bottom_y,
  input  logic [31:0]         tex_corner_one,
  input  logic [31:0]         tex_corner_two,
  input  logic [31:0]         tex_corner_three,
  input  logic [31:0]         tex_corner_four,
  output logic                push_valid,
  input  logic                push_ready,
  output sqvb_pkg::cmd_t      push_data
);

  logic [sqvb_pkg::SLOT_W-1:0] batch_vertex_count;
  logic [sqvb_pkg::SLOT_W-1:0] batch_vertex_count_next;
  logic [sqvb_pkg::SLOT_W:0]   count_plus;
  logic                        nonempty;
  logic                        full_flush;
  logic [sqvb_pkg::SLOT_W-1:0] base;
  logic                        is_flush;

  // classify the beat against the running batch count
  always_comb begin
    is_flush = (operation == sqvb_pkg::OP_FLUSH);
    nonempty = (batch_vertex_count != '0);
    count_plus = {1'b0, batch_vertex_count} + (sqvb_pkg::SLOT_W+1)'(4);
    full_flush = nonempty &&
                 ({1'b0, count_plus} >= (sqvb_pkg::SLOT_W+2)'(sqvb_pkg::BATCH_VERTICES));
    base = full_flush ? '0 : batch_vertex_count;
    if (is_flush) begin
      batch_vertex_count_next = '0;
    end else begin
      batch_vertex_count_next = base + sqvb_pkg::SLOT_W'(4);
    end
  end

  // an empty flush is taken and dropped
  assign in_ready   = push_ready;
  assign push_valid = in_valid && (!is_flush || nonempty);

  always_comb begin
    push_data.flush_only  = is_flush;
    push_data.flush_first = !is_flush && full_flush;
    push_data.base_slot   = base;
    push_data.left_x      = left_x;
    push_data.top_y       = top_y;
    push_data.right_x     = right_x;
    push_data.bottom_y    = bottom_y;
    push_data.tex[0]      = tex_corner_one;
    push_data.tex[1]      = tex_corner_two;
    push_data.tex[2]      = tex_corner_three;
    push_data.tex[3]      = tex_corner_four;
  end

  // batch count
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_vertex_count <= '0;
    end else if (in_valid && in_ready) begin
      batch_vertex_count <= batch_vertex_count_next;
    end
  end

endmodule

/* sv/sqvb_queue.sv */
module sqvb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sqvb_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sqvb_pkg::cmd_t pop_data
);

  sqvb_pkg::cmd_t                  entries [sqvb_pkg::QUEUE_DEPTH];
  logic [sqvb_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sqvb_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sqvb_pkg::QCNT_W-1:0]     fill;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (fill != sqvb_pkg::QCNT_W'(sqvb_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sqvb_pkg::QPTR_W'(sqvb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sqvb_pkg::QPTR_W'(sqvb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + sqvb_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - sqvb_pkg::QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/sqvb_back.sv */
module sqvb_back (
  input  logic           clk,
  input  logic           rst,
  input  sqvb_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sqvb_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           kind,
  output logic [31:0]    pos_x,
  output logic [31:0]    pos_y,
  output logic [31:0]    tex_uv,
  output logic [31:0]    color_rgba,
  output logic [14:0]    vertex_slot,
  output logic           last
);

  typedef struct packed {
    logic                        kind;
    logic [31:0]                 x;
    logic [31:0]                 y;
    logic [31:0]                 tex;
    logic [sqvb_pkg::SLOT_W-1:0] slot;
    logic                        last;
  } sel_t;

  typedef struct packed {
    logic                        kind;
    logic [63:0]                 p_xx;
    logic [63:0]                 p_xy;
    logic [63:0]                 p_yx;
    logic [63:0]                 p_yy;
    logic [31:0]                 tex;
    logic [sqvb_pkg::SLOT_W-1:0] slot;
    logic                        last;
  } prod_t;

  localparam logic signed [49:0] POS_MAX = 50'sd2147483647;
  localparam logic signed [49:0] POS_MIN = -50'sd2147483648;

  logic        started;
  logic [2:0]  step;
  logic [2:0]  cur_s;
  logic [1:0]  vidx;
  logic        advance;
  logic        emit;
  logic        emit_last;
  sel_t        sel_next;
  logic        a_v;
  sel_t        a_q;
  logic        b_v;
  prod_t       b_q;
  logic signed [49:0] sum_x;
  logic signed [49:0] sum_y;
  logic [31:0] sat_x;
  logic [31:0] sat_y;
  logic [31:0] color_word;

  // tint scaled by clamped alpha
  function automatic logic [31:0] make_color(logic [23:0] tint, logic [8:0] opac);
    logic [8:0]  a;
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
    logic [16:0] al;
    a  = (opac > sqvb_pkg::ALPHA_ONE) ? sqvb_pkg::ALPHA_ONE : opac;
    r  = 17'(tint[23:16]) * 17'(a);
    g  = 17'(tint[15:8]) * 17'(a);
    b  = 17'(tint[7:0]) * 17'(a);
    al = 17'(sqvb_pkg::CHAN_MAX) * 17'(a);
    if (tint == sqvb_pkg::WHITE_TINT && a == sqvb_pkg::ALPHA_ONE) begin
      return 32'hFFFF_FFFF;
    end
    return {r[15:8], g[15:8], b[15:8], al[15:8]};
  endfunction

  // whole pipeline moves when the output register can take a beat
  assign advance = !out_valid || out_ready;

  // sequencer: marker step 0, vertex steps 1 to 4
  always_comb begin
    if (started) begin
      cur_s = step;
    end else if (cmd.flush_only || cmd.flush_first) begin
      cur_s = 3'd0;
    end else begin
      cur_s = 3'd1;
    end
    vidx      = 2'(cur_s - 3'd1);
    emit      = cmd_valid && advance;
    emit_last = cmd.flush_only || (cur_s == 3'd4);
    cmd_ready = advance && emit_last;

    sel_next.last = emit_last;
    if (cur_s == 3'd0) begin
      sel_next.kind = sqvb_pkg::KIND_FLUSH;
      sel_next.x    = '0;
      sel_next.y    = '0;
      sel_next.tex  = '0;
      sel_next.slot = '0;
    end else begin
      sel_next.kind = sqvb_pkg::KIND_VERTEX;
      sel_next.x    = (vidx == 2'd0 || vidx == 2'd3) ? cmd.left_x : cmd.right_x;
      sel_next.y    = (vidx == 2'd0 || vidx == 2'd1) ? cmd.top_y : cmd.bottom_y;
      sel_next.tex  = cmd.tex[vidx];
      sel_next.slot = cmd.base_slot + sqvb_pkg::SLOT_W'(vidx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      step    <= '0;
    end else if (emit) begin
      if (emit_last) begin
        started <= 1'b0;
      end else begin
        started <= 1'b1;
        step    <= cur_s + 3'd1;
      end
    end
  end

  // select stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (advance) begin
      a_v <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_q <= sel_next;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (advance) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_q.kind <= a_q.kind;
      b_q.p_xx <= 64'($signed(cfg.m_xx)) * 64'($signed(a_q.x));
      b_q.p_xy <= 64'($signed(cfg.m_xy)) * 64'($signed(a_q.y));
      b_q.p_yx <= 64'($signed(cfg.m_yx)) * 64'($signed(a_q.x));
      b_q.p_yy <= 64'($signed(cfg.m_yy)) * 64'($signed(a_q.y));
      b_q.tex  <= a_q.tex;
      b_q.slot <= a_q.slot;
      b_q.last <= a_q.last;
    end
  end

  // floor shift, sum with translation, saturate
  always_comb begin
    sum_x = 50'($signed(b_q.p_xx) >>> 16) + 50'($signed(b_q.p_xy) >>> 16)
          + 50'($signed(cfg.m_xt));
    sum_y = 50'($signed(b_q.p_yx) >>> 16) + 50'($signed(b_q.p_yy) >>> 16)
          + 50'($signed(cfg.m_yt));
    if (sum_x > POS_MAX) begin
      sat_x = 32'h7FFF_FFFF;
    end else if (sum_x < POS_MIN) begin
      sat_x = 32'h8000_0000;
    end else begin
      sat_x = sum_x[31:0];
    end
    if (sum_y > POS_MAX) begin
      sat_y = 32'h7FFF_FFFF;
    end else if (sum_y < POS_MIN) begin
      sat_y = 32'h8000_0000;
    end else begin
      sat_y = sum_y[31:0];
    end
    color_word = make_color(cfg.tint_color, cfg.opacity);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind        <= b_q.kind;
      last        <= b_q.last;
      tex_uv      <= b_q.tex;
      vertex_slot <= b_q.slot;
      if (b_q.kind == sqvb_pkg::KIND_FLUSH) begin
        pos_x      <= '0;
        pos_y      <= '0;
        color_rgba <= '0;
      end else begin
        pos_x      <= sat_x;
        pos_y      <= sat_y;
        color_rgba <= color_word;
      end
    end
  end

endmodule

/* sv/sprite_quad_vertex_batcher_core.sv */
// sprite quad vertex batcher
// input channel (in_valid/in_ready): one beat is a quad (operation 0) with two
// corners and four texcoords, or a batch flush (operation 1).
// output channel (out_valid/out_ready): vertex beats (kind 0) with position,
// texcoord, tinted colour and batch slot, and flush marker beats (kind 1).
// a quad gives four vertices, preceded by a flush marker when the batch fills;
// a flush on a non-empty batch gives one marker, on an empty batch nothing.
// last marks the final beat of each input beat.
// config port (cfg_write/cfg_index/cfg_data) sets the affine matrix, tint and
// opacity; write only while no beats are in flight.
// an input beat's results pass through the command queue, then the select,
// multiply and output registers. throughput: one result beat per cycle while
// the receiver does not stall; each quad gives four vertex beats.
// a two-entry command queue sits between the classifier and the vertex
// pipeline, so input beats keep being taken while the receiver stalls until
// the queue fills; a stall freezes the vertex pipeline with its beats intact.
// reset clears the batch count, the queue, the pipeline and loads the identity
// matrix, white tint and full opacity.
module sprite_quad_vertex_batcher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] left_x,
  input  logic [31:0] top_y,
  input  logic [31:0] right_x,
  input  logic [31:0] bottom_y,
  input  logic [31:0] tex_corner_one,
  input  logic [31:0] tex_corner_two,
  input  logic [31:0] tex_corner_three,
  input  logic [31:0] tex_corner_four,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] tex_uv,
  output logic [31:0] color_rgba,
  output logic [14:0] vertex_slot,
  output logic        last
);

  sqvb_pkg::cfg_t cfg;
  sqvb_pkg::cmd_t push_data;
  sqvb_pkg::cmd_t pop_data;
  logic           push_valid;
  logic           push_ready;
  logic           pop_valid;
  logic           pop_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.m_xx       <= 32'd65536;
      cfg.m_xy       <= '0;
      cfg.m_xt       <= '0;
      cfg.m_yx       <= '0;
      cfg.m_yy       <= 32'd65536;
      cfg.m_yt       <= '0;
      cfg.tint_color <= sqvb_pkg::WHITE_TINT;
      cfg.opacity    <= sqvb_pkg::ALPHA_ONE;
    end else if (cfg_write) begin
      case (cfg_index)
        sqvb_pkg::REG_M_XX:    cfg.m_xx       <= cfg_data;
        sqvb_pkg::REG_M_XY:    cfg.m_xy       <= cfg_data;
        sqvb_pkg::REG_M_XT:    cfg.m_xt       <= cfg_data;
        sqvb_pkg::REG_M_YX:    cfg.m_yx       <= cfg_data;
        sqvb_pkg::REG_M_YY:    cfg.m_yy       <= cfg_data;
        sqvb_pkg::REG_M_YT:    cfg.m_yt       <= cfg_data;
        sqvb_pkg::REG_TINT:    cfg.tint_color <= cfg_data[23:0];
        sqvb_pkg::REG_OPACITY: cfg.opacity    <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // classifier and batch count
  sqvb_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .left_x           (left_x),
    .top_y            (top_y),
    .right_x          (right_x),
    .bottom_y         (bottom_y),
    .tex_corner_one   (tex_corner_one),
    .tex_corner_two   (tex_corner_two),
    .tex_corner_three (tex_corner_three),
    .tex_corner_four  (tex_corner_four),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  // command queue
  sqvb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // vertex pipeline
  sqvb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_valid   (pop_valid),
    .cmd_ready   (pop_ready),
    .cmd         (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .tex_uv      (tex_uv),
    .color_rgba  (color_rgba),
    .vertex_slot (vertex_slot),
    .last        (last)
  );

endmodule
